[hw/rtl/ws2812_dimmed_spi_encoder_core_assert.svh]
// Assertion macros for the LED encoder core.
// Used by the top level only; expects signals clk and rst_n in scope.
`ifndef WS2812_DIMMED_SPI_ENCODER_CORE_ASSERT_SVH
`define WS2812_DIMMED_SPI_ENCODER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSDSE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WSDSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/wsdse_pkg.sv]
// Shared types and constants for the LED encoder core.
// No dependencies; imported by every module of the block.
`default_nettype none

package wsdse_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_SYMBOL    = 2'd0;
    localparam logic [1:0] KIND_POWER_ON  = 2'd1;
    localparam logic [1:0] KIND_POWER_OFF = 2'd2;

    // Three-bit line patterns.
    localparam logic [2:0] SYM_ONE  = 3'b110;
    localparam logic [2:0] SYM_ZERO = 3'b100;
    localparam logic [2:0] SYM_NONE = 3'b000;

    localparam int COLOR_W = 8;
    localparam int PCT_W   = 7;
    localparam logic [PCT_W-1:0] FULL_SCALE = 7'd100;

    // c * pct / 100 equals (c * pct * 5243) >> 19 for every product below 25501.
    localparam int PROD_W = COLOR_W + PCT_W;
    localparam int RECIP_W = 13;
    localparam logic [RECIP_W-1:0] DIM_RECIP = 13'd5243;
    localparam int DIM_SHIFT = 19;
    localparam int SCALED_W = PROD_W + RECIP_W;

    localparam int WORD_W = 3 * COLOR_W;
    localparam int CNT_W  = 5;
    localparam logic [CNT_W-1:0] BIT_COUNT = 5'd24;

    // Command queue depth; must be a power of two.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_OFF,   // 24 zero symbols, then power off
        CMD_ON,    // 24 symbols, supply already on
        CMD_WAKE   // power on, then 24 symbols
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [WORD_W-1:0] word;
    } cmd_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

`default_nettype wire

[hw/rtl/ws2812_dimmed_spi_encoder_core.sv]
// Dimmed LED color encoder. Each request (red, green, blue, brightness in
// percent) becomes 24 three-bit line symbols in GRB order, most significant
// bit first, bracketed by supply events: a request after power-off first gives
// a power-on event, and an off request (zero brightness or black) gives 24 zero
// symbols and a power-off event, or nothing if the supply is already off. The
// result side delivers one result per cycle while results are popped; a request
// yields 24 or 25 results, and the symbol sequencer sets the sustained rate.
// A new request is accepted while earlier ones are still being sent: a dimming
// stage and a two-entry command queue hold up to three requests ahead of the
// sequencer. A request passes the dimming stage, the queue and the sequencer
// to the output register. Depends on wsdse_pkg and the assertion macro header.
`default_nettype none

`include "ws2812_dimmed_spi_encoder_core_assert.svh"

module ws2812_dimmed_spi_encoder_core
    import wsdse_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [COLOR_W-1:0] red,
    input  wire logic [COLOR_W-1:0] green,
    input  wire logic [COLOR_W-1:0] blue,
    input  wire logic [COLOR_W-1:0] brightness,
    output logic                    empty,
    input  wire logic               pop,
    output logic [1:0]              kind,
    output logic [2:0]              symbol,
    output logic                    last
);

    fifo_status_t fifo_st;
    logic         wr_en, rd_en;
    cmd_entry_t   wr_entry, rd_entry;

    wsdse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .brightness (brightness),
        .full       (full),
        .fifo_st    (fifo_st),
        .wr_en      (wr_en),
        .wr_entry   (wr_entry)
    );

    wsdse_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_entry (wr_entry),
        .rd_en    (rd_en),
        .rd_entry (rd_entry),
        .status   (fifo_st)
    );

    wsdse_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .fifo_st  (fifo_st),
        .rd_entry (rd_entry),
        .rd_en    (rd_en),
        .pop      (pop),
        .empty    (empty),
        .kind     (kind),
        .symbol   (symbol),
        .last     (last)
    );

    // The queue can never claim to be both full and empty.
    `WSDSE_ASSERT_SAME(a_fifo_flags, fifo_st.full, !fifo_st.empty, "queue full and empty at once")

    // A result that is not the last of its item is followed at once by another.
    `WSDSE_ASSERT_NEXT(a_no_gap, pop && !empty && !last, !empty, "gap inside an item's results")

    // A power-on event is always followed by a symbol.
    `WSDSE_ASSERT_NEXT(a_wake_then_symbol, pop && !empty && (kind == KIND_POWER_ON),
        !empty && (kind == KIND_SYMBOL), "power-on event not followed by a symbol")

endmodule

`default_nettype wire

[hw/rtl/wsdse_front.sv]
// Front end: accepts requests, tracks the supply flag, classifies and dims.
// Depends on wsdse_pkg; feeds wsdse_fifo.
`default_nettype none

module wsdse_front
    import wsdse_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire logic [COLOR_W-1:0]  red,
    input  wire logic [COLOR_W-1:0]  green,
    input  wire logic [COLOR_W-1:0]  blue,
    input  wire logic [COLOR_W-1:0]  brightness,
    output logic                     full,
    input  wire fifo_status_t        fifo_st,
    output logic                     wr_en,
    output cmd_entry_t               wr_entry
);

    logic              s1_valid_reg, s1_valid_next;
    logic              power_reg, power_next;
    cmd_t              s1_cmd_reg, s1_cmd_next;
    logic [PROD_W-1:0] s1_prod_g_reg, s1_prod_r_reg, s1_prod_b_reg;
    logic [PROD_W-1:0] s1_prod_g_next, s1_prod_r_next, s1_prod_b_next;
    logic              accept, is_off, drop;
    logic [PCT_W-1:0]  pct;

    function automatic logic [COLOR_W-1:0] dim_of(input logic [PROD_W-1:0] prod);
        logic [SCALED_W-1:0] scaled;
        scaled = SCALED_W'(prod) * SCALED_W'(DIM_RECIP);
        return scaled[DIM_SHIFT +: COLOR_W];
    endfunction

    always_comb
    begin
        full   = s1_valid_reg && fifo_st.full;
        wr_en  = s1_valid_reg && !fifo_st.full;
        accept = push && !full;
        is_off = (brightness == '0) || ((red | green | blue) == '0);
        drop   = is_off && !power_reg;
        pct    = (brightness > COLOR_W'(FULL_SCALE)) ? FULL_SCALE : brightness[PCT_W-1:0];

        s1_valid_next  = s1_valid_reg && !wr_en;
        power_next     = power_reg;
        s1_cmd_next    = s1_cmd_reg;
        s1_prod_g_next = s1_prod_g_reg;
        s1_prod_r_next = s1_prod_r_reg;
        s1_prod_b_next = s1_prod_b_reg;

        // An off request while the supply is off causes nothing and is dropped here.
        if (accept && !drop)
        begin
            s1_valid_next = 1'b1;
            if (is_off)
            begin
                s1_cmd_next    = CMD_OFF;
                power_next     = 1'b0;
                s1_prod_g_next = '0;
                s1_prod_r_next = '0;
                s1_prod_b_next = '0;
            end
            else
            begin
                s1_cmd_next    = power_reg ? CMD_ON : CMD_WAKE;
                power_next     = 1'b1;
                s1_prod_g_next = PROD_W'(green) * PROD_W'(pct);
                s1_prod_r_next = PROD_W'(red) * PROD_W'(pct);
                s1_prod_b_next = PROD_W'(blue) * PROD_W'(pct);
            end
        end

        wr_entry.cmd  = s1_cmd_reg;
        wr_entry.word = {dim_of(s1_prod_g_reg), dim_of(s1_prod_r_reg), dim_of(s1_prod_b_reg)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            power_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            power_reg    <= power_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg    <= s1_cmd_next;
        s1_prod_g_reg <= s1_prod_g_next;
        s1_prod_r_reg <= s1_prod_r_next;
        s1_prod_b_reg <= s1_prod_b_next;
    end

endmodule

`default_nettype wire

[hw/rtl/wsdse_fifo.sv]
// Short command queue between the front end and the symbol sequencer.
// Depends on wsdse_pkg.
`default_nettype none

module wsdse_fifo
    import wsdse_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  wire cmd_entry_t wr_entry,
    input  wire logic       rd_en,
    output cmd_entry_t      rd_entry,
    output fifo_status_t    status
);

    cmd_entry_t              entries_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;
    logic                    do_wr, do_rd;

    always_comb
    begin
        status.full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
        status.empty = (count_reg == '0);
        do_wr        = wr_en && !status.full;
        do_rd        = rd_en && !status.empty;
        rd_entry     = entries_reg[rd_ptr_reg];

        wr_ptr_next = do_wr ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/wsdse_back.sv]
// Symbol sequencer: turns one queued command into its results, one per cycle while
// the output is popped, through a registered output stage. Depends on wsdse_pkg.
`default_nettype none

module wsdse_back
    import wsdse_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire fifo_status_t fifo_st,
    input  wire cmd_entry_t   rd_entry,
    output logic              rd_en,
    input  wire logic         pop,
    output logic              empty,
    output logic [1:0]        kind,
    output logic [2:0]        symbol,
    output logic              last
);

    logic              busy_reg, busy_next;
    cmd_t              cmd_reg, cmd_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              wake_reg, wake_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        kind_reg, kind_next;
    logic [2:0]        symbol_reg, symbol_next;
    logic              last_reg, last_next;
    logic              out_load, emit, final_res;
    logic [1:0]        em_kind;
    logic [2:0]        em_sym;
    logic              em_last;

    always_comb
    begin
        out_load  = !out_valid_reg || pop;
        emit      = busy_reg && out_load;
        em_kind   = KIND_SYMBOL;
        em_sym    = word_reg[WORD_W-1] ? SYM_ONE : SYM_ZERO;
        em_last   = 1'b0;
        final_res = 1'b0;

        if (wake_reg)
        begin
            em_kind = KIND_POWER_ON;
            em_sym  = SYM_NONE;
        end
        else if (cnt_reg == BIT_COUNT)
        begin
            // Only an off command gets past the last symbol.
            em_kind   = KIND_POWER_OFF;
            em_sym    = SYM_NONE;
            em_last   = 1'b1;
            final_res = 1'b1;
        end
        else if ((cnt_reg == BIT_COUNT - CNT_W'(1)) && (cmd_reg != CMD_OFF))
        begin
            em_last   = 1'b1;
            final_res = 1'b1;
        end

        busy_next = busy_reg;
        cmd_next  = cmd_reg;
        word_next = word_reg;
        cnt_next  = cnt_reg;
        wake_next = wake_reg;

        if (emit)
        begin
            if (wake_reg)
            begin
                wake_next = 1'b0;
            end
            else if (cnt_reg != BIT_COUNT)
            begin
                word_next = {word_reg[WORD_W-2:0], 1'b0};
                cnt_next  = cnt_reg + CNT_W'(1);
            end
            if (final_res)
            begin
                busy_next = 1'b0;
            end
        end

        // The next command loads in the cycle that the current one finishes.
        rd_en = !fifo_st.empty && (!busy_reg || (emit && final_res));
        if (rd_en)
        begin
            busy_next = 1'b1;
            cmd_next  = rd_entry.cmd;
            word_next = rd_entry.word;
            cnt_next  = '0;
            wake_next = (rd_entry.cmd == CMD_WAKE);
        end

        out_valid_next = out_load ? emit : out_valid_reg;
        kind_next      = kind_reg;
        symbol_next    = symbol_reg;
        last_next      = last_reg;
        if (emit)
        begin
            kind_next   = em_kind;
            symbol_next = em_sym;
            last_next   = em_last;
        end

        empty  = !out_valid_reg;
        kind   = kind_reg;
        symbol = symbol_reg;
        last   = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            wake_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            wake_reg      <= wake_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        word_reg   <= word_next;
        kind_reg   <= kind_next;
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
    end

endmodule

`default_nettype wire
